// ----- hw/rtl/trrq_pkg.sv -----
// Package for the timed-release ready queue: command codes, status codes
// and the controller state type. No dependencies.
package trrq_pkg;

   // Command codes carried on the request channel
   localparam logic [2:0] CMD_ADD_READY = 3'd0;
   localparam logic [2:0] CMD_ADD_PEND  = 3'd1;
   localparam logic [2:0] CMD_REM_READY = 3'd2;
   localparam logic [2:0] CMD_REM_PEND  = 3'd3;
   localparam logic [2:0] CMD_RELEASE   = 3'd4;
   localparam logic [2:0] CMD_ROTATE    = 3'd5;

   // Status codes returned on the response channel
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_MISS = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS,
      ST_RSCAN,
      ST_PSCAN,
      ST_REL,
      ST_CMPRD,
      ST_CMP,
      ST_ROT,
      ST_HEAD,
      ST_RESP
   } state_type;

endpackage

// ----- hw/rtl/timed_release_ready_queue_top.sv -----
// Timed-release ready queue top level: request decode, sequencer and response
// register around two trrq_ram instances. Depends on trrq_pkg and trrq_ram.
//
// One request is processed at a time; a response is always returned. Sorted
// insert, remove and release walk the pending list or ready ring one entry
// per cycle through the memory read port; release has a move phase and then
// compaction of the pending list. A new request is taken while the previous
// response still waits.
module timed_release_ready_queue_top
   import trrq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8,
   parameter int TIME_BITS   = 16,
   localparam int PTR_W      = $clog2(QUEUE_DEPTH),
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_command,
   input  logic [ID_BITS-1:0]   req_process_id,
   input  logic [TIME_BITS-1:0] req_creation_time,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [ID_BITS-1:0]   rsp_head_id,
   output logic [CNT_W-1:0]     rsp_ready_count,
   output logic [CNT_W-1:0]     rsp_pending_count,
   output logic [TIME_BITS-1:0] rsp_next_time,
   output logic [CNT_W-1:0]     rsp_moved_count
);

   localparam int PW = ID_BITS + TIME_BITS;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   // ring slot of an offset from the ready head
   function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] start,
                                             input logic [CNT_W-1:0] off);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(start) + (CNT_W+1)'(off);
      if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
         s = s - (CNT_W+1)'(QUEUE_DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [TIME_BITS-1:0] rel_time_ff, rel_time_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 found_ff, found_in;
   logic [CNT_W-1:0]     moved_ff, moved_in;
   logic [1:0]           status_ff, status_in;
   logic [PTR_W-1:0]     rstart_ff, rstart_in;
   logic [CNT_W-1:0]     rused_ff, rused_in;
   logic [CNT_W-1:0]     pused_ff, pused_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]   rsp_head_ff, rsp_head_in;
   logic [CNT_W-1:0]     rsp_rcnt_ff, rsp_rcnt_in;
   logic [CNT_W-1:0]     rsp_pcnt_ff, rsp_pcnt_in;
   logic [TIME_BITS-1:0] rsp_time_ff, rsp_time_in;
   logic [CNT_W-1:0]     rsp_moved_ff, rsp_moved_in;

   // memory ports
   logic                 r_we, p_we;
   logic [PTR_W-1:0]     r_waddr, r_raddr, p_waddr, p_raddr;
   logic [ID_BITS-1:0]   r_wdata, r_rdata;
   logic [PW-1:0]        p_wdata, p_rdata;
   logic [ID_BITS-1:0]   p_rid;
   logic [TIME_BITS-1:0] p_rtime;
   logic                 accept, match, same_time;
   logic [CNT_W-1:0]     idx_m1, idx_p1, idx_m2, last;
   logic [CNT_W-1:0]     pused_m1, cmp_src;

   trrq_ram #(.WIDTH(ID_BITS), .DEPTH(QUEUE_DEPTH), .AW(PTR_W)) u_ready_ram (
      .clock (clock),
      .we    (r_we),
      .waddr (r_waddr),
      .wdata (r_wdata),
      .raddr (r_raddr),
      .rdata (r_rdata)
   );

   trrq_ram #(.WIDTH(PW), .DEPTH(QUEUE_DEPTH), .AW(PTR_W)) u_pend_ram (
      .clock (clock),
      .we    (p_we),
      .waddr (p_waddr),
      .wdata (p_wdata),
      .raddr (p_raddr),
      .rdata (p_rdata)
   );

   assign p_rid     = p_rdata[PW-1:TIME_BITS];
   assign p_rtime   = p_rdata[TIME_BITS-1:0];
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign idx_m1    = idx_ff - CNT_W'(1);
   assign idx_m2    = idx_ff - CNT_W'(2);
   assign idx_p1    = idx_ff + CNT_W'(1);
   assign pused_m1  = pused_ff - CNT_W'(1);
   assign cmp_src   = idx_p1 + moved_ff;

   // state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rstart_ff    <= '0;
         rused_ff     <= '0;
         pused_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rstart_ff    <= rstart_in;
         rused_ff     <= rused_in;
         pused_ff     <= pused_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      time_ff       <= time_in;
      rel_time_ff   <= rel_time_in;
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      moved_ff      <= moved_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_rcnt_ff   <= rsp_rcnt_in;
      rsp_pcnt_ff   <= rsp_pcnt_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_moved_ff  <= rsp_moved_in;
   end

   // sequencer: next state, memory accesses and response load
   always_comb begin
      state_in     = state_ff;
      id_in        = id_ff;
      time_in      = time_ff;
      rel_time_in  = rel_time_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      moved_in     = moved_ff;
      status_in    = status_ff;
      rstart_in    = rstart_ff;
      rused_in     = rused_ff;
      pused_in     = pused_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_head_in  = rsp_head_ff;
      rsp_rcnt_in  = rsp_rcnt_ff;
      rsp_pcnt_in  = rsp_pcnt_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_moved_in = rsp_moved_ff;
      r_we    = 1'b0;
      r_waddr = slot(rstart_ff, rused_ff);
      r_wdata = p_rid;
      r_raddr = rstart_ff;
      p_we    = 1'b0;
      p_waddr = idx_ff[PTR_W-1:0];
      p_wdata = p_rdata;
      p_raddr = '0;
      match     = 1'b0;
      same_time = 1'b0;
      last      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               id_in     = req_process_id;
               time_in   = req_creation_time;
               idx_in    = '0;
               found_in  = 1'b0;
               moved_in  = '0;
               status_in = STAT_OK;
               state_in  = ST_HEAD;
               unique case (req_command)
                  CMD_ADD_READY: begin
                     if (rused_ff == FULL_CNT) begin
                        status_in = STAT_FULL;
                     end else begin
                        r_we     = 1'b1;
                        r_wdata  = req_process_id;
                        rused_in = rused_ff + CNT_W'(1);
                     end
                  end
                  CMD_ADD_PEND: begin
                     if (pused_ff == FULL_CNT) begin
                        status_in = STAT_FULL;
                     end else begin
                        // walk from the tail, shifting later times up
                        p_raddr  = pused_m1[PTR_W-1:0];
                        idx_in   = pused_ff;
                        state_in = ST_INS;
                     end
                  end
                  CMD_REM_READY: begin
                     if (rused_ff == '0) begin
                        status_in = STAT_MISS;
                     end else begin
                        r_raddr  = rstart_ff;
                        state_in = ST_RSCAN;
                     end
                  end
                  CMD_REM_PEND: begin
                     if (pused_ff == '0) begin
                        status_in = STAT_MISS;
                     end else begin
                        p_raddr  = '0;
                        state_in = ST_PSCAN;
                     end
                  end
                  CMD_RELEASE: begin
                     if (pused_ff == '0) begin
                        status_in = STAT_MISS;
                     end else begin
                        p_raddr  = '0;
                        state_in = ST_REL;
                     end
                  end
                  CMD_ROTATE: begin
                     if (rused_ff == '0) begin
                        status_in = STAT_MISS;
                     end else if (rused_ff != CNT_W'(1)) begin
                        r_raddr  = rstart_ff;
                        state_in = ST_ROT;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // sorted insert: read data is entry idx-1
         ST_INS: begin
            p_we    = 1'b1;
            p_waddr = idx_ff[PTR_W-1:0];
            p_raddr = idx_m2[PTR_W-1:0];
            if (idx_ff != '0 && time_ff < p_rtime) begin
               p_wdata = p_rdata;
               idx_in  = idx_m1;
            end else begin
               p_wdata  = {id_ff, time_ff};
               pused_in = pused_ff + CNT_W'(1);
               state_in = ST_HEAD;
            end
         end

         // ready remove: find first match, then close the gap
         ST_RSCAN: begin
            last    = rused_ff - CNT_W'(1);
            r_raddr = slot(rstart_ff, idx_p1);
            match   = (r_rdata == id_ff);
            r_wdata = r_rdata;
            r_waddr = slot(rstart_ff, idx_m1);
            r_we    = found_ff;
            found_in = found_ff || match;
            if (idx_ff == last) begin
               state_in = ST_HEAD;
               if (found_ff || match) begin
                  rused_in = last;
               end else begin
                  status_in = STAT_MISS;
               end
            end else begin
               idx_in = idx_p1;
            end
         end

         // pending remove: same walk on the sorted list
         ST_PSCAN: begin
            last    = pused_ff - CNT_W'(1);
            p_raddr = idx_p1[PTR_W-1:0];
            match   = (p_rid == id_ff);
            p_wdata = p_rdata;
            p_waddr = idx_m1[PTR_W-1:0];
            p_we    = found_ff;
            found_in = found_ff || match;
            if (idx_ff == last) begin
               state_in = ST_HEAD;
               if (found_ff || match) begin
                  pused_in = last;
               end else begin
                  status_in = STAT_MISS;
               end
            end else begin
               idx_in = idx_p1;
            end
         end

         // release: move head entries sharing the first time to ready, until ready is full
         ST_REL: begin
            p_raddr   = idx_p1[PTR_W-1:0];
            same_time = (idx_ff == '0) || (p_rtime == rel_time_ff);
            if (idx_ff == '0) begin
               rel_time_in = p_rtime;
            end
            if (!same_time) begin
               pused_in = pused_ff - moved_ff;
               state_in = ST_CMPRD;
            end else if (rused_ff == FULL_CNT) begin
               status_in = STAT_FULL;
               pused_in  = pused_ff - moved_ff;
               state_in  = ST_CMPRD;
            end else begin
               r_we     = 1'b1;
               r_wdata  = p_rid;
               rused_in = rused_ff + CNT_W'(1);
               moved_in = moved_ff + CNT_W'(1);
               if (idx_p1 == pused_ff) begin
                  pused_in = pused_ff - moved_in;
                  state_in = ST_CMPRD;
               end else begin
                  idx_in = idx_p1;
               end
            end
         end

         // start compaction of the pending list
         ST_CMPRD: begin
            p_raddr = moved_ff[PTR_W-1:0];
            idx_in  = '0;
            if (moved_ff == '0 || pused_ff == '0) begin
               state_in = ST_HEAD;
            end else begin
               state_in = ST_CMP;
            end
         end

         ST_CMP: begin
            p_we    = 1'b1;
            p_waddr = idx_ff[PTR_W-1:0];
            p_wdata = p_rdata;
            p_raddr = cmp_src[PTR_W-1:0];
            if (idx_p1 == pused_ff) begin
               state_in = ST_HEAD;
            end else begin
               idx_in = idx_p1;
            end
         end

         // rotate: copy head to tail slot, advance head
         ST_ROT: begin
            r_we      = 1'b1;
            r_wdata   = r_rdata;
            r_waddr   = slot(rstart_ff, rused_ff);
            rstart_in = slot(rstart_ff, CNT_W'(1));
            state_in  = ST_HEAD;
         end

         ST_HEAD: begin
            r_raddr  = rstart_ff;
            p_raddr  = '0;
            state_in = ST_RESP;
         end

         // load response register once it is free
         ST_RESP: begin
            r_raddr = rstart_ff;
            p_raddr = '0;
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_head_in   = (rused_ff != '0) ? r_rdata : '0;
               rsp_rcnt_in   = rused_ff;
               rsp_pcnt_in   = pused_ff;
               rsp_time_in   = (pused_ff != '0) ? p_rtime : '0;
               rsp_moved_in  = moved_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_head_id       = rsp_head_ff;
   assign rsp_ready_count   = rsp_rcnt_ff;
   assign rsp_pending_count = rsp_pcnt_ff;
   assign rsp_next_time     = rsp_time_ff;
   assign rsp_moved_count   = rsp_moved_ff;

   // occupancy never exceeds the store depth
   a_rused_max: assert property (@(posedge clock) disable iff (reset)
      rused_ff <= FULL_CNT) else $error("ready count overflow");

   a_pused_max: assert property (@(posedge clock) disable iff (reset)
      pused_ff <= FULL_CNT) else $error("pending count overflow");

   // a response is only produced from the response state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("response without request completion");

   // a release cannot move more entries than the pending list held
   a_moved_le: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REL) |-> (moved_ff <= pused_ff))
      else $error("release moved too many entries");

endmodule

// ----- hw/rtl/trrq_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the ready ring and the pending list. No dependencies.
module trrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- dv/trrq_checker.sv -----
// Checker for the timed-release ready queue: watches the request and response
// channels, keeps its own scheduler state and compares every response.
// Depends on trrq_pkg.
module trrq_checker
   import trrq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_process_id,
   input  logic [15:0] req_creation_time,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [7:0]  rsp_head_id,
   input  logic [4:0]  rsp_ready_count,
   input  logic [4:0]  rsp_pending_count,
   input  logic [15:0] rsp_next_time,
   input  logic [4:0]  rsp_moved_count,
   output int          fail_count,
   output int          open_count
);

   localparam int DEPTH = 16;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  head_id;
      logic [4:0]  ready_count;
      logic [4:0]  pending_count;
      logic [15:0] next_time;
      logic [4:0]  moved_count;
   } snapshot_type;

   // scheduler state mirror
   logic [7:0]   ring_ids [DEPTH];
   logic [3:0]   ring_head;
   int           ring_used;
   logic [7:0]   wait_ids [DEPTH];
   logic [15:0]  wait_times [DEPTH];
   int           wait_used;
   snapshot_type pending_rsp [$];

   function automatic logic [3:0] slot(int off);
      return 4'((int'(ring_head) + off) % DEPTH);
   endfunction

   function automatic bit ring_push(logic [7:0] id);
      if (ring_used >= DEPTH) return 0;
      ring_ids[slot(ring_used)] = id;
      ring_used++;
      return 1;
   endfunction

   function automatic void wait_pop(int pos);
      for (int k = pos; k + 1 < wait_used; k++) begin
         wait_ids[k] = wait_ids[k+1];
         wait_times[k] = wait_times[k+1];
      end
      wait_used--;
   endfunction

   // apply one request and return the response it should produce
   function automatic snapshot_type schedule(logic [2:0] cmd, logic [7:0] id, logic [15:0] t);
      snapshot_type r;
      int pos;
      logic [15:0] rel_t;
      r = '0;
      r.status = STAT_OK;
      case (cmd)
         CMD_ADD_READY: if (!ring_push(id)) r.status = STAT_FULL;
         CMD_ADD_PEND: begin
            if (wait_used >= DEPTH) r.status = STAT_FULL;
            else begin
               pos = 0;
               while (pos < wait_used && !(t < wait_times[pos])) pos++;
               for (int k = wait_used; k > pos; k--) begin
                  wait_ids[k] = wait_ids[k-1];
                  wait_times[k] = wait_times[k-1];
               end
               wait_ids[pos] = id;
               wait_times[pos] = t;
               wait_used++;
            end
         end
         CMD_REM_READY: begin
            pos = 0;
            while (pos < ring_used && ring_ids[slot(pos)] != id) pos++;
            if (pos >= ring_used) r.status = STAT_MISS;
            else begin
               for (int k = pos; k + 1 < ring_used; k++) ring_ids[slot(k)] = ring_ids[slot(k+1)];
               ring_used--;
            end
         end
         CMD_REM_PEND: begin
            pos = 0;
            while (pos < wait_used && wait_ids[pos] != id) pos++;
            if (pos >= wait_used) r.status = STAT_MISS;
            else wait_pop(pos);
         end
         CMD_RELEASE: begin
            if (wait_used == 0) r.status = STAT_MISS;
            else begin
               rel_t = wait_times[0];
               while (wait_used > 0 && wait_times[0] == rel_t && r.status == STAT_OK) begin
                  if (!ring_push(wait_ids[0])) r.status = STAT_FULL;
                  else begin
                     wait_pop(0);
                     r.moved_count++;
                  end
               end
            end
         end
         CMD_ROTATE: begin
            if (ring_used == 0) r.status = STAT_MISS;
            else if (ring_used > 1) begin
               ring_ids[slot(ring_used)] = ring_ids[ring_head];
               ring_head = slot(1);
            end
         end
         default: ;
      endcase
      r.head_id = ring_used ? ring_ids[ring_head] : 8'd0;
      r.ready_count = 5'(ring_used);
      r.pending_count = 5'(wait_used);
      r.next_time = wait_used ? wait_times[0] : 16'd0;
      return r;
   endfunction

   // predict on accepted requests, compare on accepted responses
   always @(posedge clock) begin
      snapshot_type got, exp;
      if (reset) begin
         ring_head = '0;
         ring_used = 0;
         wait_used = 0;
         pending_rsp.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            pending_rsp.push_back(schedule(req_command, req_process_id, req_creation_time));
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_head_id, rsp_ready_count, rsp_pending_count,
                   rsp_next_time, rsp_moved_count};
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected response %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               exp = pending_rsp.pop_front();
               if (got != exp) begin
                  $display("%0t: mismatch expected st=%0d hd=%0d rc=%0d pc=%0d nt=%0d mv=%0d",
                           $time, exp.status, exp.head_id, exp.ready_count,
                           exp.pending_count, exp.next_time, exp.moved_count);
                  $display("%0t:          actual   st=%0d hd=%0d rc=%0d pc=%0d nt=%0d mv=%0d",
                           $time, got.status, got.head_id, got.ready_count,
                           got.pending_count, got.next_time, got.moved_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      open_count = pending_rsp.size();
   end

endmodule

// ----- dv/timed_release_ready_queue_top_test.sv -----
// Testbench top for the timed-release ready queue: clock, reset, request
// stimulus, response stalling and verdict. Depends on trrq_pkg, trrq_checker and timed_release_ready_queue_top.
module timed_release_ready_queue_top_test;
   import trrq_pkg::*;

   localparam int WATCH_LIMIT = 4000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_command;
   logic [7:0]  req_process_id;
   logic [15:0] req_creation_time;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_head_id;
   logic [4:0]  rsp_ready_count;
   logic [4:0]  rsp_pending_count;
   logic [15:0] rsp_next_time;
   logic [4:0]  rsp_moved_count;
   int          fail_count;
   int          open_count;
   bit          hold_rsp;
   bit          stim_done;
   int          quiet_cycles;
   logic [7:0]  live_ids [$];

   timed_release_ready_queue_top uut (.*);

   trrq_checker chk (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // send one request and wait until it is taken
   task automatic send(logic [2:0] cmd, logic [7:0] id, logic [15:0] t);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_process_id <= id;
      req_creation_time <= t;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic gap();
      int n;
      n = $urandom_range(0, 5);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // ids from a small pool so removes hit often
   function automatic logic [7:0] pick_id();
      if (live_ids.size() > 0 && $urandom_range(0, 2) != 0)
         return live_ids[$urandom_range(0, live_ids.size() - 1)];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic random_item();
      int r;
      logic [2:0] cmd;
      logic [7:0] id;
      r = $urandom_range(0, 99);
      cmd = r < 20 ? CMD_ADD_READY : r < 42 ? CMD_ADD_PEND : r < 55 ? CMD_REM_READY :
            r < 67 ? CMD_REM_PEND : r < 82 ? CMD_RELEASE : r < 97 ? CMD_ROTATE :
            3'($urandom_range(6, 7));
      id = (cmd == CMD_ADD_READY || cmd == CMD_ADD_PEND) ? 8'($urandom_range(0, 255))
                                                        : pick_id();
      if (cmd == CMD_ADD_READY || cmd == CMD_ADD_PEND) begin
         live_ids.push_back(id);
         if (live_ids.size() > 24) void'(live_ids.pop_front());
      end
      // few distinct times so releases move groups; sometimes full range
      send(cmd, id, $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 65535))
                                             : 16'($urandom_range(0, 6)));
      gap();
   endtask

   // response side: random stall per response, plus a long hold on request
   initial begin
      int n;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         n = $urandom_range(0, 5);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else if (open_count > 0 || !stim_done)
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_ADD_READY;
      req_process_id = '0;
      req_creation_time = '0;
      stim_done = 0;
      hold_rsp = 0;
      quiet_cycles = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty-store misses and unused codes
      send(CMD_RELEASE, 8'd0, 16'd0);
      send(CMD_ROTATE, 8'd0, 16'd0);
      send(CMD_REM_READY, 8'd5, 16'd0);
      send(CMD_REM_PEND, 8'd5, 16'd0);
      send(3'd6, 8'hff, 16'hffff);
      send(3'd7, 8'h00, 16'h0000);
      // single entry rotate, extremes of id and time
      send(CMD_ADD_READY, 8'hff, 16'd0);
      send(CMD_ROTATE, 8'd0, 16'd0);
      send(CMD_ADD_PEND, 8'h00, 16'hffff);
      send(CMD_ADD_PEND, 8'haa, 16'h0000);
      send(CMD_ADD_PEND, 8'h55, 16'h0000);
      // duplicate id: only first match goes
      send(CMD_ADD_PEND, 8'haa, 16'h0000);
      send(CMD_REM_PEND, 8'haa, 16'd0);
      send(CMD_RELEASE, 8'd0, 16'd0);
      // fill ready, overflow, then release against full ready
      for (int i = 0; i < 16; i++) send(CMD_ADD_READY, 8'(i + 1), 16'd0);
      send(CMD_ADD_PEND, 8'h77, 16'hffff);
      send(CMD_RELEASE, 8'd0, 16'd0);
      send(CMD_REM_READY, 8'd3, 16'd0);
      send(CMD_ROTATE, 8'd0, 16'd0);
      send(CMD_RELEASE, 8'd0, 16'd0);
      // fill pending to overflow
      for (int i = 0; i < 17; i++) send(CMD_ADD_PEND, 8'(i), 16'(i % 3));
      req_valid <= 1'b0;
      wait (open_count == 0);
      // removes on the ready ring with ids picked from the live pool
      for (int i = 0; i < 20; i++) send(CMD_REM_READY, pick_id(), 16'd0);

      // random part with a long response hold and a drain pause
      for (int i = 0; i < 500; i++) begin
         if (i == 150) hold_rsp = 1;
         if (i == 300) begin
            req_valid <= 1'b0;
            wait (open_count == 0);
            @(posedge clock);
         end
         random_item();
      end
      req_valid <= 1'b0;
      stim_done = 1;
      wait (open_count == 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- timed_release_ready_queue_top.f -----
hw/rtl/trrq_pkg.sv
hw/rtl/trrq_ram.sv
hw/rtl/timed_release_ready_queue_top.sv
dv/trrq_checker.sv
dv/timed_release_ready_queue_top_test.sv
